>>> hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define MD5_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define MD5_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/md5_pkg.sv
// md5 core package: constants, round tables, sequencer states
`default_nettype none

package md5_pkg;

   localparam int WORD_W        = 32;
   localparam int BLOCK_WORDS   = 16;
   localparam int WORD_ADDR_W   = $clog2(BLOCK_WORDS);
   localparam int ROUNDS        = 64;
   localparam int ROUND_CNT_W   = $clog2(ROUNDS + 1);
   localparam int DIGEST_WORDS  = 4;

   localparam logic [WORD_ADDR_W-1:0] LEN_LO_WORD = 4'd14;
   localparam logic [WORD_ADDR_W-1:0] LEN_HI_WORD = 4'd15;
   localparam logic [WORD_ADDR_W-1:0] LAST_WORD   = 4'd15;
   localparam logic [1:0]             LAST_DIGEST = 2'd3;
   localparam logic [1:0]             LAST_LANE   = 2'd3;
   localparam logic [5:0]             LAST_POS    = 6'd63;
   localparam logic [7:0]             PAD_BYTE    = 8'h80;

   localparam logic [WORD_W-1:0] INIT_HASH [DIGEST_WORDS] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   localparam logic [WORD_W-1:0] ROUND_CONST [ROUNDS] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] ROT_AMOUNT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_FILL,
      ST_ROUND,
      ST_ADD,
      ST_EMIT
   } md5_state_type;

   // message word used by a given round
   function automatic logic [WORD_ADDR_W-1:0] word_select(input logic [5:0] round);
      logic [3:0] lo;
      logic [3:0] sel;
      lo = round[3:0];
      case (round[5:4])
         2'd0:    sel = lo;
         2'd1:    sel = (lo << 2) + lo + 4'd1;
         2'd2:    sel = (lo << 1) + lo + 4'd5;
         default: sel = (lo << 3) - lo;
      endcase
      return sel;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/md5_ram.sv
// generic single write port ram with registered read
`default_nettype none

module md5_ram #(
   parameter int WIDTH = md5_pkg::WORD_W,
   parameter int DEPTH = md5_pkg::BLOCK_WORDS
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/md5_round.sv
// one md5 step: round function, constant add, rotate, feed-forward add
`default_nettype none

module md5_round (
   input  wire logic [31:0] a_word,
   input  wire logic [31:0] b_word,
   input  wire logic [31:0] c_word,
   input  wire logic [31:0] d_word,
   input  wire logic [31:0] msg_word,
   input  wire logic [5:0]  round,
   output logic      [31:0] new_b
);

   logic [31:0] func;
   logic [31:0] sum;
   logic [4:0]  shift;
   logic [63:0] rot_wide;

   // boolean function for the current quarter
   always_comb begin
      case (round[5:4])
         2'd0:    func = (b_word & c_word) | (~b_word & d_word);
         2'd1:    func = (b_word & d_word) | (c_word & ~d_word);
         2'd2:    func = b_word ^ c_word ^ d_word;
         default: func = c_word ^ (b_word | ~d_word);
      endcase
   end

   // add chain, left rotate, add b
   assign sum      = a_word + func + md5_pkg::ROUND_CONST[round] + msg_word;
   assign shift    = md5_pkg::ROT_AMOUNT[{round[5:4], round[1:0]}];
   assign rot_wide = {sum, sum} << shift;
   assign new_b    = b_word + rot_wide[63:32];

endmodule

`default_nettype wire

>>> hw/rtl/md5_message_digest_core.sv
// md5 message digest core: byte intake, padding sequencer, iterative compression
//
// MD5 over a byte stream. Each request carries at most one message byte and
// may end the message; the digest then comes out as four responses, word A
// first, each word to be read least significant byte first. While a block is
// filling, one request is taken per cycle. Taking the 64th byte of a block
// starts a compression (a word-buffer read, 64 rounds through the single round
// unit, the chaining add), during which req_stall is high. An end mark brings
// a padding step that writes the word with the end marker, then the zero and
// length words still to write (up to 15 in one block, up to 17 when the
// padding spills into a second block), and one or two compressions; then the
// four digest words follow, one per cycle when not stalled. There is no
// clearing pass after reset.
`default_nettype none

module md5_message_digest_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_byte_valid,
   input  wire logic        req_is_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [31:0] rsp_digest_word,
   output logic      [1:0]  rsp_word_index,
   output logic             rsp_last_word
);

   localparam int AW = md5_pkg::WORD_ADDR_W;
   localparam int RW = md5_pkg::ROUND_CNT_W;

   md5_pkg::md5_state_type state_ff, state_in;

   logic [63:0]   count_ff, count_in;
   logic [23:0]   acc_ff, acc_in;
   logic [AW-1:0] wc_ff, wc_in;
   logic [RW-1:0] rnd_ff, rnd_in;
   logic [1:0]    emit_ff, emit_in;
   logic          last_ff, last_in;
   logic          pad_done_ff, pad_done_in;
   logic          final_blk_ff, final_blk_in;
   logic [31:0]   hash_ff [md5_pkg::DIGEST_WORDS];
   logic [31:0]   hash_in [md5_pkg::DIGEST_WORDS];
   logic [31:0]   a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;
   logic [AW-1:0] rd_addr;
   logic [31:0]   rd_data;
   logic [31:0]   pad_word;
   logic [63:0]   bit_len;
   logic [5:0]    cur_round;
   logic [31:0]   new_b;
   logic [AW-1:0] pad_idx;

   // message word buffer
   md5_ram #(
      .WIDTH (32),
      .DEPTH (md5_pkg::BLOCK_WORDS)
   ) u_word_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared round unit
   md5_round u_round (
      .a_word   (a_ff),
      .b_word   (b_ff),
      .c_word   (c_ff),
      .d_word   (d_ff),
      .msg_word (rd_data),
      .round    (cur_round),
      .new_b    (new_b)
   );

   // word read in the cycle before the round that uses it
   assign cur_round = rnd_ff[5:0] - 6'd1;
   assign rd_addr   = md5_pkg::word_select(rnd_ff[5:0]);
   assign bit_len   = {count_ff[60:0], 3'b000};
   assign pad_idx   = count_ff[5:2];

   // word holding the end marker: kept bytes, 0x80, zeros
   always_comb begin
      pad_word = '0;
      for (int k = 0; k < 3; k++) begin
         if (2'(k) < count_ff[1:0]) begin
            pad_word[8*k +: 8] = acc_ff[8*k +: 8];
         end
      end
      pad_word[{count_ff[1:0], 3'b000} +: 8] = md5_pkg::PAD_BYTE;
   end

   // state and data registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= md5_pkg::ST_IDLE;
         count_ff     <= '0;
         wc_ff        <= '0;
         rnd_ff       <= '0;
         emit_ff      <= '0;
         last_ff      <= 1'b0;
         pad_done_ff  <= 1'b0;
         final_blk_ff <= 1'b0;
         hash_ff      <= md5_pkg::INIT_HASH;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wc_ff        <= wc_in;
         rnd_ff       <= rnd_in;
         emit_ff      <= emit_in;
         last_ff      <= last_in;
         pad_done_ff  <= pad_done_in;
         final_blk_ff <= final_blk_in;
         hash_ff      <= hash_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
   end

   // sequencer: next state, buffer writes, round updates
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      acc_in       = acc_ff;
      wc_in        = wc_ff;
      rnd_in       = rnd_ff;
      emit_in      = emit_ff;
      last_in      = last_ff;
      pad_done_in  = pad_done_ff;
      final_blk_in = final_blk_ff;
      hash_in      = hash_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      wr_en        = 1'b0;
      wr_addr      = wc_ff;
      wr_data      = '0;

      case (state_ff)
         md5_pkg::ST_IDLE: begin
            if (req_valid) begin
               // take the byte, write a word once four are in
               if (req_byte_valid) begin
                  count_in = count_ff + 64'd1;
                  if (count_ff[1:0] == md5_pkg::LAST_LANE) begin
                     wr_en   = 1'b1;
                     wr_addr = pad_idx;
                     wr_data = {req_data_byte, acc_ff};
                  end else begin
                     acc_in[{count_ff[1:0], 3'b000} +: 8] = req_data_byte;
                  end
               end
               if (req_is_last) begin
                  last_in     = 1'b1;
                  pad_done_in = 1'b0;
               end
               if (req_byte_valid && count_ff[5:0] == md5_pkg::LAST_POS) begin
                  state_in = md5_pkg::ST_ROUND;
               end else if (req_is_last) begin
                  state_in = md5_pkg::ST_PAD;
               end
            end
         end

         md5_pkg::ST_PAD: begin
            wr_en       = 1'b1;
            wr_addr     = pad_idx;
            wr_data     = pad_word;
            pad_done_in = 1'b1;
            // no room for the length: this block ends in zeros
            if (pad_idx == md5_pkg::LAST_WORD) begin
               final_blk_in = 1'b0;
               state_in     = md5_pkg::ST_ROUND;
            end else if (pad_idx == md5_pkg::LEN_LO_WORD) begin
               final_blk_in = 1'b0;
               wc_in        = md5_pkg::LAST_WORD;
               state_in     = md5_pkg::ST_FILL;
            end else begin
               final_blk_in = 1'b1;
               wc_in        = pad_idx + 4'd1;
               state_in     = md5_pkg::ST_FILL;
            end
         end

         md5_pkg::ST_FILL: begin
            // zero words, bit length in the last two of the final block
            wr_en   = 1'b1;
            wr_addr = wc_ff;
            if (final_blk_ff && wc_ff == md5_pkg::LEN_LO_WORD) begin
               wr_data = bit_len[31:0];
            end else if (final_blk_ff && wc_ff == md5_pkg::LEN_HI_WORD) begin
               wr_data = bit_len[63:32];
            end
            if (wc_ff == md5_pkg::LAST_WORD) begin
               state_in = md5_pkg::ST_ROUND;
            end else begin
               wc_in = wc_ff + 4'd1;
            end
         end

         md5_pkg::ST_ROUND: begin
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == '0) begin
               a_in = hash_ff[0];
               b_in = hash_ff[1];
               c_in = hash_ff[2];
               d_in = hash_ff[3];
            end else begin
               a_in = d_ff;
               b_in = new_b;
               c_in = b_ff;
               d_in = c_ff;
            end
            if (rnd_ff == RW'(md5_pkg::ROUNDS)) begin
               rnd_in   = '0;
               state_in = md5_pkg::ST_ADD;
            end
         end

         md5_pkg::ST_ADD: begin
            // fold the working words into the chaining words
            hash_in[0] = hash_ff[0] + a_ff;
            hash_in[1] = hash_ff[1] + b_ff;
            hash_in[2] = hash_ff[2] + c_ff;
            hash_in[3] = hash_ff[3] + d_ff;
            if (!last_ff) begin
               state_in = md5_pkg::ST_IDLE;
            end else if (!pad_done_ff) begin
               state_in = md5_pkg::ST_PAD;
            end else if (final_blk_ff) begin
               emit_in  = '0;
               state_in = md5_pkg::ST_EMIT;
            end else begin
               wc_in        = '0;
               final_blk_in = 1'b1;
               state_in     = md5_pkg::ST_FILL;
            end
         end

         md5_pkg::ST_EMIT: begin
            // hand out A..D, then start the next message
            if (!rsp_stall) begin
               if (emit_ff == md5_pkg::LAST_DIGEST) begin
                  hash_in  = md5_pkg::INIT_HASH;
                  count_in = '0;
                  last_in  = 1'b0;
                  emit_in  = '0;
                  state_in = md5_pkg::ST_IDLE;
               end else begin
                  emit_in = emit_ff + 2'd1;
               end
            end
         end

         default: begin
            state_in = md5_pkg::ST_IDLE;
         end
      endcase
   end

   // channel outputs
   assign req_stall       = (state_ff != md5_pkg::ST_IDLE);
   assign rsp_valid       = (state_ff == md5_pkg::ST_EMIT);
   assign rsp_digest_word = hash_ff[emit_ff];
   assign rsp_word_index  = emit_ff;
   assign rsp_last_word   = (emit_ff == md5_pkg::LAST_DIGEST);

endmodule

`default_nettype wire

>>> hw/rtl/md5_checker.sv
// port-level checks for the md5 core, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module md5_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [7:0]  req_data_byte,
   input wire logic        req_byte_valid,
   input wire logic        req_is_last,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_digest_word,
   input wire logic [1:0]  rsp_word_index,
   input wire logic        rsp_last_word
);

   // last flag marks exactly word D
   `MD5_ASSERT(a_last_flag, clock, reset, rsp_valid |-> (rsp_last_word == (rsp_word_index == 2'd3)), "last_word not on word D")

   // digest words come in order without gaps
   `MD5_ASSERT(a_word_order, clock, reset, rsp_valid && !rsp_stall && !rsp_last_word |=> rsp_valid && (rsp_word_index == 2'($past(rsp_word_index) + 2'd1)), "digest word order broken")

   // no request taken while a digest is pending
   `MD5_ASSERT(a_no_req_in_emit, clock, reset, rsp_valid |-> req_stall, "request accepted during digest output")

   // stalled response holds
   `MD5_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digest_word) && $stable(rsp_word_index), "stalled response changed")

   // reset leaves no response pending
   `MD5_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind md5_message_digest_core md5_checker u_md5_checker (.*);

`default_nettype wire

>>> dv/tb_top.sv
// testbench for the md5 message digest core: byte stream requests, digest checks
`timescale 1ns / 1ps

module tb_top;

   // limits on the run
   localparam int MSG_ITEMS   = 420;
   localparam int QUIET_LIMIT = 4000;
   localparam int TAIL_CYCLES = 200;

   // md5 framing
   localparam logic [7:0] PAD_MARK   = 8'h80;
   localparam int         LEN_OFFSET = 56;
   localparam int         BLK_BYTES  = 64;
   localparam logic [1:0] FINAL_WORD = 2'd3;

   localparam logic [31:0] CHAIN_INIT [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   localparam logic [31:0] SINE_ADD [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam int ROT_BY [16] = '{
      7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
   };

   // idle percentages per stage of the run
   localparam int SEND_IDLE_PCT [3] = '{29, 87, 0};
   localparam int RECV_IDLE_PCT [3] = '{87, 29, 0};

   typedef struct {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       is_last;
      int         stage;
      bit         drain_first;
   } md5_request_t;

   typedef struct {
      logic [31:0] digest_word;
      logic [1:0]  word_index;
      logic        last_word;
   } digest_word_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_byte_valid = 1'b0;
   logic        req_is_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [1:0]  rsp_word_index;
   logic        rsp_last_word;

   // predictor state
   logic [31:0] chain_words [4] = CHAIN_INIT;
   logic [7:0]  block_bytes [64];
   logic [63:0] msg_bytes = 64'd0;

   md5_request_t request_queue [$];
   digest_word_t digest_words_due [$];
   md5_request_t drive_item;
   digest_word_t got_word;
   int          run_stage = 0;
   int          mismatches = 0;
   int          quiet_cycles = 0;
   int          last_stage = 0;
   int          random_items = 0;

   md5_message_digest_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_byte_valid  (req_byte_valid),
      .req_is_last     (req_is_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   // clock and reset
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // one 64-round compression of the block into the chaining words
   function automatic void md5_compress_block();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, f, t, sum;
      int          g;
      int          s;
      for (int i = 0; i < 16; i++) begin
         w[i] = {block_bytes[4*i+3], block_bytes[4*i+2], block_bytes[4*i+1], block_bytes[4*i]};
      end
      a = chain_words[0];
      b = chain_words[1];
      c = chain_words[2];
      d = chain_words[3];
      for (int r = 0; r < 64; r++) begin
         case (r / 16)
            0: begin
               f = (b & c) | (~b & d);
               g = r;
            end
            1: begin
               f = (b & d) | (c & ~d);
               g = (5 * r + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               g = (3 * r + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               g = (7 * r) % 16;
            end
         endcase
         s   = ROT_BY[(r / 16) * 4 + r % 4];
         sum = a + f + SINE_ADD[r] + w[g];
         t   = d;
         d   = c;
         c   = b;
         b   = b + ((sum << s) | (sum >> (32 - s)));
         a   = t;
      end
      chain_words[0] += a;
      chain_words[1] += b;
      chain_words[2] += c;
      chain_words[3] += d;
   endfunction

   // take one accepted request, queue the digest when it ends a message
   function automatic void md5_absorb_request(md5_request_t rq);
      int           pos;
      logic [63:0]  bit_len;
      digest_word_t dw;
      pos = int'(msg_bytes[5:0]);
      if (rq.byte_valid) begin
         block_bytes[pos] = rq.data_byte;
         msg_bytes = msg_bytes + 64'd1;
         pos = int'(msg_bytes[5:0]);
         if (pos == 0) md5_compress_block();
      end
      if (!rq.is_last) return;
      block_bytes[pos] = PAD_MARK;
      pos++;
      // no room for the length: finish this block and pad a fresh one
      if (pos > LEN_OFFSET) begin
         while (pos < BLK_BYTES) begin
            block_bytes[pos] = 8'h00;
            pos++;
         end
         md5_compress_block();
         pos = 0;
      end
      while (pos < LEN_OFFSET) begin
         block_bytes[pos] = 8'h00;
         pos++;
      end
      bit_len = msg_bytes << 3;
      for (int k = 0; k < 8; k++) block_bytes[LEN_OFFSET + k] = bit_len[8*k +: 8];
      md5_compress_block();
      for (int k = 0; k < 4; k++) begin
         dw.digest_word = chain_words[k];
         dw.word_index  = 2'(k);
         dw.last_word   = (2'(k) == FINAL_WORD);
         digest_words_due.push_back(dw);
      end
      chain_words = CHAIN_INIT;
      msg_bytes   = 64'd0;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) md5_absorb_request(drive_item);
         if (!req_valid || !req_stall) begin
            if (request_queue.size() != 0
                && !(request_queue[0].drain_first && digest_words_due.size() != 0)
                && $urandom_range(0, 99) >= SEND_IDLE_PCT[request_queue[0].stage]) begin
               drive_item = request_queue.pop_front();
               run_stage  = drive_item.stage;
               req_valid      <= 1'b1;
               req_data_byte  <= drive_item.data_byte;
               req_byte_valid <= drive_item.byte_valid;
               req_is_last    <= drive_item.is_last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // digest monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (digest_words_due.size() == 0) begin
               $error("digest word %h with no request pending", rsp_digest_word);
               mismatches++;
            end else begin
               got_word = digest_words_due.pop_front();
               if (rsp_digest_word !== got_word.digest_word) begin
                  $error("digest_word expected %h got %h", got_word.digest_word,
                         rsp_digest_word);
                  mismatches++;
               end
               if (rsp_word_index !== got_word.word_index) begin
                  $error("word_index expected %0d got %0d", got_word.word_index,
                         rsp_word_index);
                  mismatches++;
               end
               if (rsp_last_word !== got_word.last_word) begin
                  $error("last_word expected %0d got %0d", got_word.last_word,
                         rsp_last_word);
                  mismatches++;
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < RECV_IDLE_PCT[run_stage]);
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // queue one request, stage follows progress through the random part
   task automatic push_request(input logic [7:0] data, input logic bv, input logic last,
                               input bit counted);
      md5_request_t rq;
      int           stg;
      stg = (random_items * 3) / MSG_ITEMS;
      if (stg > 2) stg = 2;
      rq.data_byte   = data;
      rq.byte_valid  = bv;
      rq.is_last     = last;
      rq.stage       = stg;
      rq.drain_first = (stg != last_stage);
      last_stage     = stg;
      if (counted) random_items++;
      request_queue.push_back(rq);
   endtask

   // one message of random bytes, with stray no-op requests mixed in
   task automatic queue_message(input int len);
      logic [7:0] b;
      bit         last_on_byte;
      last_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < 6) push_request(8'($urandom), 1'b0, 1'b0, 1'b0);
         case ($urandom_range(0, 9))
            0:       b = 8'h00;
            1:       b = 8'hff;
            default: b = 8'($urandom_range(0, 255));
         endcase
         push_request(b, 1'b1, last_on_byte && (i == len - 1), 1'b1);
      end
      if (!last_on_byte) push_request(8'($urandom), 1'b0, 1'b1, 1'b1);
   endtask

   // stimulus
   initial begin
      int edge_lens [12] = '{0, 1, 54, 55, 56, 57, 62, 63, 64, 65, 119, 120};
      int len;

      // directed: no-op, empty message, one-byte messages, short message
      push_request(8'h5a, 1'b0, 1'b0, 1'b0);
      push_request(8'ha5, 1'b0, 1'b1, 1'b0);
      push_request(8'hff, 1'b1, 1'b1, 1'b0);
      push_request(8'h00, 1'b1, 1'b0, 1'b0);
      push_request(8'h00, 1'b0, 1'b1, 1'b0);
      push_request(8'h61, 1'b1, 1'b0, 1'b0);
      push_request(8'h62, 1'b1, 1'b0, 1'b0);
      push_request(8'h63, 1'b1, 1'b1, 1'b0);
      push_request(8'h80, 1'b1, 1'b0, 1'b0);
      push_request(8'h7f, 1'b0, 1'b0, 1'b0);
      push_request(8'h01, 1'b0, 1'b1, 1'b0);

      // hold the sender until the empty-message digest is all out
      request_queue[2].drain_first = 1'b1;

      // random messages, lengths weighted toward block and padding boundaries
      while (random_items < MSG_ITEMS) begin
         if ($urandom_range(0, 99) < 35) len = edge_lens[$urandom_range(0, 11)];
         else len = $urandom_range(0, 20);
         queue_message(len);
      end

      do @(posedge clock);
      while (request_queue.size() != 0 || req_valid || digest_words_due.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && digest_words_due.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
